/* hw/rtl/b2da_pkg.sv */
// Shared constants and a helper for the binary to decimal ASCII converter.
package b2da_pkg;

	localparam int VALUE_BITS_DEFAULT = 64;
	localparam int IN_WIDTH           = 64;
	localparam int ASCII_WIDTH        = 6;
	localparam int STEP_BITS          = 4;
	localparam int MAX_DIGITS         = 20;
	localparam logic [ASCII_WIDTH-1:0] ASCII_ZERO = 6'd48;

	function automatic int dec_digits(input int bits);
		logic [63:0] v;
		int n;
		v = (bits >= 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
		n = 0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (v != 64'd0) begin
				n = n + 1;
				v = v / 64'd10;
			end
		end
		return (n < 1) ? 1 : n;
	endfunction

endpackage

/* hw/rtl/b2da_dabble_stage.sv */
// One pipeline stage of double dabble: several shift and add-3 steps, registered.
module b2da_dabble_stage import b2da_pkg::*; #(
	parameter int NDIG = MAX_DIGITS,
	parameter int PAD  = IN_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [PAD-1:0]    in_bin,
	input  logic [NDIG*4-1:0] in_bcd,
	output logic              out_valid,
	output logic [PAD-1:0]    out_bin,
	output logic [NDIG*4-1:0] out_bcd
);

	logic [PAD-1:0]    bin_nx;
	logic [NDIG*4-1:0] bcd_nx;

	always_comb begin
		bin_nx = in_bin;
		bcd_nx = in_bcd;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_nx[d*4 +: 4] >= 4'd5) begin
					bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
				end
			end
			bcd_nx = {bcd_nx[NDIG*4-2:0], bin_nx[PAD-1]};
			bin_nx = {bin_nx[PAD-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_bin <= bin_nx;
			out_bcd <= bcd_nx;
		end
	end

endmodule

/* hw/rtl/b2da_digit_emit.sv */
// Digit emitter: drops leading zeros, sends a value's digits in ASCII.
module b2da_digit_emit import b2da_pkg::*; #(
	parameter int NDIG = MAX_DIGITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [NDIG*4-1:0]      load_bcd,
	output logic                   can_load,
	output logic                   digit_valid,
	input  logic                   digit_stall,
	output logic [ASCII_WIDTH-1:0] ascii_digit,
	output logic                   last
);

	localparam int CW = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam logic [CW-1:0] CNT_TOP = CW'(NDIG - 1);

	logic [NDIG*4-1:0]      bcd_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   lead_q;
	logic                   out_valid_q;
	logic [ASCII_WIDTH-1:0] out_digit_q;
	logic                   out_last_q;
	logic [3:0]             top;
	logic                   take;
	logic                   out_free;
	logic                   skip;
	logic                   emit;

	assign top      = bcd_q[NDIG*4-1 -: 4];
	assign take     = out_valid_q && !digit_stall;
	assign out_free = !out_valid_q || take;
	assign skip     = busy_q && lead_q && (top == 4'd0) && (cnt_q != '0);
	assign emit     = busy_q && !skip && out_free;
	assign can_load = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			lead_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				lead_q <= 1'b1;
				cnt_q  <= CNT_TOP;
			end else if (skip) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (emit) begin
				lead_q <= 1'b0;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= load_bcd;
		end else if (skip || emit) begin
			bcd_q <= {bcd_q[NDIG*4-5:0], 4'd0};
		end
		if (emit) begin
			out_digit_q <= ASCII_ZERO + {2'b00, top};
			out_last_q  <= (cnt_q == '0);
		end
	end

	assign digit_valid = out_valid_q;
	assign ascii_digit = out_digit_q;
	assign last        = out_last_q;

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_digit_q >= ASCII_ZERO) && (out_digit_q <= ASCII_ZERO + 6'd9))
		else $error("digit out of range");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && lead_q)
		else $error("load did not start a run");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (cnt_q == '0) |=> !busy_q && out_valid_q && out_last_q)
		else $error("run end not flagged");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q)
		else $error("load while busy");

endmodule

/* hw/rtl/binary_to_decimal_ascii_core.sv */
// Top level: pipelined double dabble converter feeding a decimal digit emitter.
// Converts an unsigned VALUE_BITS number to ASCII decimal digits, most significant first,
// no leading zeros, with last set on the final digit. The conversion runs in a pipeline
// of ceil(VALUE_BITS/4) stages (four shift/add-3 steps each). The emitter walks every
// digit position once, one per cycle while the output is not stalled, dropping leading
// zeros and sending the rest; it covers NDIG positions per value (20 for 64 bits) and
// takes the next value only after the last digit of the previous one, so a value waiting
// at the end of the pipeline stalls all stages and the input.
module binary_to_decimal_ascii_core import b2da_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   value_valid,
	output logic                   value_stall,
	input  logic [IN_WIDTH-1:0]    value,
	output logic                   digit_valid,
	input  logic                   digit_stall,
	output logic [ASCII_WIDTH-1:0] ascii_digit,
	output logic                   last
);

	localparam int NDIG   = dec_digits(VALUE_BITS);
	localparam int NSTAGE = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD    = NSTAGE * STEP_BITS;

	logic              pipe_valid [NSTAGE+1];
	logic [PAD-1:0]    pipe_bin   [NSTAGE+1];
	logic [NDIG*4-1:0] pipe_bcd   [NSTAGE+1];
	logic              adv;
	logic              can_load;
	logic              load;

	always_comb begin
		pipe_bin[0]                 = '0;
		pipe_bin[0][VALUE_BITS-1:0] = value[VALUE_BITS-1:0];
	end
	assign pipe_valid[0] = value_valid;
	assign pipe_bcd[0]   = '0;

	assign load        = pipe_valid[NSTAGE] && can_load;
	assign adv         = !pipe_valid[NSTAGE] || can_load;
	assign value_stall = !adv;

	for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
		b2da_dabble_stage #(
			.NDIG (NDIG),
			.PAD  (PAD)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (pipe_valid[k]),
			.in_bin    (pipe_bin[k]),
			.in_bcd    (pipe_bcd[k]),
			.out_valid (pipe_valid[k+1]),
			.out_bin   (pipe_bin[k+1]),
			.out_bcd   (pipe_bcd[k+1])
		);
	end

	b2da_digit_emit #(
		.NDIG (NDIG)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.load_bcd    (pipe_bcd[NSTAGE]),
		.can_load    (can_load),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall),
		.ascii_digit (ascii_digit),
		.last        (last)
	);

endmodule

/* sim/tb_top.sv */
// Testbench for binary_to_decimal_ascii_core: table and random requests against a predictor.
`timescale 1ns / 1ps

module tb_top;
	import b2da_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int NUM_RANDOM     = 64;

	typedef struct packed {
		logic [ASCII_WIDTH-1:0] ascii;
		logic                   is_last;
	} digit_t;

	typedef struct {
		logic [IN_WIDTH-1:0] value;
		string               text;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   value_valid;
	logic                   value_stall;
	logic [IN_WIDTH-1:0]    value;
	logic                   digit_valid;
	logic                   digit_stall;
	logic [ASCII_WIDTH-1:0] ascii_digit;
	logic                   last;

	digit_t pending_digits[$];
	int     mismatches;
	int     idle_cycles;
	bit     quiet_phase;
	int     hold_off;

	binary_to_decimal_ascii_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall),
		.ascii_digit (ascii_digit),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void predict_digits(input logic [IN_WIDTH-1:0] number);
		logic [IN_WIDTH-1:0] v;
		logic [3:0]          rev[$];
		digit_t              d;
		v = number;
		do begin
			rev.push_back(4'(v % 64'd10));
			v = v / 64'd10;
		end while (v != 64'd0);
		for (int k = rev.size() - 1; k >= 0; k--) begin
			d.ascii   = ASCII_ZERO + ASCII_WIDTH'(rev[k]);
			d.is_last = (k == 0);
			pending_digits.push_back(d);
		end
	endfunction

	function automatic logic [IN_WIDTH-1:0] random_value();
		logic [IN_WIDTH-1:0] r;
		int                  width;
		r = {$urandom(), $urandom()};
		width = $urandom_range(1, 64);
		if (width < 64)
			r = r & ((64'd1 << width) - 64'd1);
		return r;
	endfunction

	task automatic send_value(input logic [IN_WIDTH-1:0] number, input bit allow_gap);
		if (allow_gap && !quiet_phase && $urandom_range(0, 3) == 0) begin
			value_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		value_valid <= 1'b1;
		value       <= number;
		@(posedge clk);
		while (value_stall) @(posedge clk);
		predict_digits(number);
	endtask

	// digit checker
	always @(posedge clk) begin
		digit_t exp_d;
		if (arst_n && digit_valid && !digit_stall) begin
			if (pending_digits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digit: ascii=%0d last=%0b", ascii_digit, last);
			end else begin
				exp_d = pending_digits.pop_front();
				if (exp_d.ascii !== ascii_digit || exp_d.is_last !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digit mismatch: exp ascii=%0d last=%0b, got ascii=%0d last=%0b",
							exp_d.ascii, exp_d.is_last, ascii_digit, last);
				end
			end
		end
	end

	// receiver stall
	initial begin
		digit_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				digit_stall <= 1'b1;
				hold_off    <= hold_off - 1;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				digit_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				digit_stall <= 1'b0;
			end else begin
				digit_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (value_valid && !value_stall) || (digit_valid && !digit_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** binary_to_decimal_ascii_core: FAILED **");
			$finish;
		end
	end

	initial begin
		dir_row_t rows[$];
		rows = '{
			'{64'd0, "0"},
			'{64'd1, "1"},
			'{64'd9, "9"},
			'{64'd10, "10"},
			'{64'd99, "99"},
			'{64'd100, "100"},
			'{64'd4294967295, "4294967295"},
			'{64'd999999999999999999, "999999999999999999"},
			'{64'd1000000000000000000, "1000000000000000000"},
			'{64'd9999999999999999999, "9999999999999999999"},
			'{64'd10000000000000000000, "10000000000000000000"},
			'{64'hFFFFFFFFFFFFFFFF, "18446744073709551615"},
			'{64'h8000000000000000, "9223372036854775808"},
			'{64'h5555555555555555, ""},
			'{64'hAAAAAAAAAAAAAAAA, ""},
			'{64'd1234567890, ""}
		};
		mismatches  = 0;
		idle_cycles = 0;
		quiet_phase = 1'b0;
		hold_off    = 0;
		arst_n      = 1'b0;
		value_valid = 1'b0;
		value       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			digit_t d;
			if (rows[i].text.len() == 0) begin
				send_value(rows[i].value, 1'b1);
			end else begin
				value_valid <= 1'b1;
				value       <= rows[i].value;
				@(posedge clk);
				while (value_stall) @(posedge clk);
				for (int k = 0; k < rows[i].text.len(); k++) begin
					d.ascii   = ASCII_WIDTH'(rows[i].text[k]);
					d.is_last = (k == rows[i].text.len() - 1);
					pending_digits.push_back(d);
				end
			end
		end

		// hold off the receiver so the pipeline fills and stalls its input
		hold_off <= 300;
		for (int i = 0; i < 20; i++) send_value(random_value(), 1'b0);

		// drain before continuing
		value_valid <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM - 20) quiet_phase = 1'b1;
			send_value(random_value(), 1'b1);
		end
		value_valid <= 1'b0;

		while (pending_digits.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("** binary_to_decimal_ascii_core: PASSED **");
		else
			$display("** binary_to_decimal_ascii_core: FAILED **");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_dabble_stage.sv
hw/rtl/b2da_digit_emit.sv
hw/rtl/binary_to_decimal_ascii_core.sv
sim/tb_top.sv
